@@ src/mpwm_pkg.sv @@
// Shared opcodes, constants and reset-value helpers for the multichannel PWM generator.
package mpwm_pkg;

  localparam int OPCODE_W   = 3;
  localparam int CHAN_W     = 4;
  localparam int TICKS_W    = 24;
  localparam int FRAC_W     = 17;
  localparam int PULSE_W    = 32;
  localparam int PINS_W     = 16;
  localparam int FRAC_SHIFT = 16;

  localparam logic [OPCODE_W-1:0] OP_TICK       = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_PERIOD = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SET_DUTY   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ENABLE     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SET_PULSES = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_READ       = 3'd5;

  localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'd65536;
  localparam logic [31:0]       ROUND_HALF = 32'd32768;
  localparam logic [32:0]       DEF_PERIOD = 33'd1000;
  localparam logic [32:0]       DEF_DUTY   = 33'd500;

  // Default period, saturated to the largest value the phase counter can hold.
  function automatic logic [31:0] rst_period(input int cbits);
    logic [32:0] cmax;
    cmax = (33'd1 << cbits) - 33'd1;
    return (cmax < DEF_PERIOD) ? cmax[31:0] : DEF_PERIOD[31:0];
  endfunction

  function automatic logic [31:0] rst_duty(input int cbits);
    logic [31:0] p;
    p = rst_period(cbits);
    return (DEF_DUTY[31:0] > p) ? p : DEF_DUTY[31:0];
  endfunction

endpackage

@@ src/multichannel_pwm_generator.sv @@
// Top level: request sequencer of the multichannel PWM generator with pulse counters.
// One request is taken at a time. A tick visits every channel through the single read
// port of the channel store, one channel per cycle, stepping through S_TICK for each
// channel and then S_DRAIN and S_RESP before the block can accept again. Set-period
// requests with a nonzero period and set-duty requests pass through S_READ, S_EXEC,
// S_DUTY and S_RESP because the duty product is registered; a zero-period set, enable,
// set-pulses, read and the unused opcodes skip S_DUTY, and a non-tick request for a
// channel out of range goes straight to S_RESP. A stalled response holds the block in
// S_RESP until the response is taken. The response register lets the next request
// enter while a response still waits.
module multichannel_pwm_generator #(
  parameter int CHANNELS     = 16,
  parameter int COUNTER_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [mpwm_pkg::OPCODE_W-1:0]     opcode,
  input  logic [mpwm_pkg::CHAN_W-1:0]       channel,
  input  logic [mpwm_pkg::TICKS_W-1:0]      period_len,
  input  logic [mpwm_pkg::FRAC_W-1:0]       duty_fraction,
  input  logic                              enable_value,
  input  logic [mpwm_pkg::PULSE_W-1:0]      count_value,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [mpwm_pkg::PINS_W-1:0]       pin_levels,
  output logic                              ok,
  output logic [mpwm_pkg::PULSE_W-1:0]      pulse_total,
  output logic                              channel_enabled,
  output logic [mpwm_pkg::TICKS_W-1:0]      period_value,
  output logic [mpwm_pkg::TICKS_W-1:0]      duty_value
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CB = COUNTER_BITS;
  localparam int PW = mpwm_pkg::PULSE_W;

  localparam logic [CB-1:0] CMAX       = '1;
  localparam logic [CB-1:0] RST_PERIOD = CB'(mpwm_pkg::rst_period(CB));
  localparam logic [CB-1:0] RST_DUTY   = CB'(mpwm_pkg::rst_duty(CB));
  localparam logic [AW-1:0] LAST_IDX   = AW'(CHANNELS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_DUTY  = 3'd3;
  localparam logic [2:0] S_TICK  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [mpwm_pkg::OPCODE_W-1:0] op_q;
  logic [mpwm_pkg::CHAN_W-1:0]   ch_q;
  logic [mpwm_pkg::TICKS_W-1:0]  per_q;
  logic [mpwm_pkg::FRAC_W-1:0]   frac_q;
  logic                          en_q;
  logic [PW-1:0]                 cnt_q;
  logic                          valid_q;

  logic [AW-1:0]       idx;
  logic                p_valid;
  logic [AW-1:0]       p_idx;
  logic [CHANNELS-1:0] active;
  logic [CHANNELS-1:0] pins;

  logic [CB-1:0] res_period;
  logic [CB-1:0] res_duty;
  logic [PW-1:0] res_pulse;
  logic          res_en;

  logic [AW-1:0] ch_idx;
  logic          req_ok;
  logic [CB-1:0] per_sat;
  logic          accept;

  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CB-1:0] wr_period;
  logic [CB-1:0] wr_duty;
  logic [CB-1:0] wr_phase;
  logic [PW-1:0] wr_pulse;
  logic [CB-1:0] rd_period;
  logic [CB-1:0] rd_duty;
  logic [CB-1:0] rd_phase;
  logic [PW-1:0] rd_pulse;

  logic [CB-1:0] step_phase;
  logic [PW-1:0] step_pulse;
  logic          step_pin;

  logic [CB-1:0] mul_period;
  logic [CB-1:0] duty_calc;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign req_ok    = 32'(channel) < 32'(CHANNELS);
  assign ch_idx    = ch_q[AW-1:0];
  assign per_sat   = (33'(per_q) > 33'(CMAX)) ? CMAX : CB'(per_q);
  assign rd_addr   = (state == S_TICK) ? idx : ch_idx;
  assign mul_period = (op_q == mpwm_pkg::OP_SET_PERIOD) ? per_sat : rd_period;

  mpwm_mem #(
    .CHANNELS     (CHANNELS),
    .COUNTER_BITS (CB),
    .AW           (AW)
  ) u_mem (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_period (wr_period),
    .wr_duty   (wr_duty),
    .wr_phase  (wr_phase),
    .wr_pulse  (wr_pulse),
    .rd_period (rd_period),
    .rd_duty   (rd_duty),
    .rd_phase  (rd_phase),
    .rd_pulse  (rd_pulse)
  );

  mpwm_step #(
    .COUNTER_BITS (CB)
  ) u_step (
    .period     (rd_period),
    .duty       (rd_duty),
    .phase      (rd_phase),
    .pulse      (rd_pulse),
    .phase_next (step_phase),
    .pulse_next (step_pulse),
    .pin_next   (step_pin)
  );

  mpwm_duty #(
    .COUNTER_BITS (CB)
  ) u_duty (
    .clk    (clk),
    .period (mul_period),
    .frac   (frac_q),
    .duty   (duty_calc)
  );

  // Store write port and next state.
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = ch_idx;
    wr_period  = rd_period;
    wr_duty    = rd_duty;
    wr_phase   = rd_phase;
    wr_pulse   = rd_pulse;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == mpwm_pkg::OP_TICK) begin
            state_next = S_TICK;
          end else if (req_ok) begin
            state_next = S_READ;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESP;
        unique case (op_q)
          mpwm_pkg::OP_SET_PERIOD: begin
            if (per_q == '0) begin
              wr_en     = 1'b1;
              wr_period = RST_PERIOD;
              wr_duty   = RST_DUTY;
              wr_phase  = '0;
            end else begin
              state_next = S_DUTY;
            end
          end
          mpwm_pkg::OP_SET_DUTY: begin
            state_next = S_DUTY;
          end
          mpwm_pkg::OP_SET_PULSES: begin
            wr_en    = 1'b1;
            wr_pulse = cnt_q;
          end
          default: begin
          end
        endcase
      end
      S_DUTY: begin
        wr_en   = 1'b1;
        wr_duty = duty_calc;
        if (op_q == mpwm_pkg::OP_SET_PERIOD) begin
          wr_period = per_sat;
          wr_phase  = '0;
        end
        state_next = S_RESP;
      end
      S_TICK, S_DRAIN: begin
        wr_addr  = p_idx;
        wr_en    = p_valid && active[p_idx];
        wr_phase = step_phase;
        wr_pulse = step_pulse;
        if (state == S_DRAIN) begin
          state_next = S_RESP;
        end else if (idx == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      active  <= '0;
      pins    <= '0;
      p_valid <= 1'b0;
      idx     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          idx     <= '0;
          p_valid <= 1'b0;
        end
        S_EXEC: begin
          if (op_q == mpwm_pkg::OP_SET_PERIOD && per_q == '0) begin
            active[ch_idx] <= 1'b0;
            pins[ch_idx]   <= 1'b0;
          end else if (op_q == mpwm_pkg::OP_ENABLE) begin
            active[ch_idx] <= en_q;
            if (!en_q) begin
              pins[ch_idx] <= 1'b0;
            end
          end
        end
        S_DUTY: begin
          if (op_q == mpwm_pkg::OP_SET_PERIOD) begin
            active[ch_idx] <= 1'b1;
          end
        end
        S_TICK, S_DRAIN: begin
          // The read for channel idx is issued while channel p_idx is updated.
          p_valid <= (state == S_TICK);
          idx     <= idx + AW'(1);
          if (p_valid && active[p_idx]) begin
            pins[p_idx] <= step_pin;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request capture, and the addressed channel's values as they stand after the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= opcode;
      ch_q    <= channel;
      per_q   <= period_len;
      frac_q  <= duty_fraction;
      en_q    <= enable_value;
      cnt_q   <= count_value;
      valid_q <= req_ok;
    end
    if (state == S_TICK || state == S_DRAIN) begin
      p_idx <= idx;
    end
    if (state == S_EXEC) begin
      res_period <= wr_period;
      res_duty   <= wr_duty;
      res_pulse  <= wr_pulse;
      if (op_q == mpwm_pkg::OP_SET_PERIOD) begin
        res_en <= 1'b0;
      end else if (op_q == mpwm_pkg::OP_ENABLE) begin
        res_en <= en_q;
      end else begin
        res_en <= active[ch_idx];
      end
    end
    if (state == S_DUTY) begin
      res_period <= wr_period;
      res_duty   <= wr_duty;
      res_pulse  <= wr_pulse;
      res_en     <= (op_q == mpwm_pkg::OP_SET_PERIOD) ? 1'b1 : active[ch_idx];
    end
    if ((state == S_TICK || state == S_DRAIN) && p_valid && p_idx == ch_idx) begin
      res_period <= rd_period;
      res_duty   <= rd_duty;
      res_pulse  <= active[p_idx] ? step_pulse : rd_pulse;
      res_en     <= active[p_idx];
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_RESP && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && (!rsp_valid || !rsp_stall)) begin
      pin_levels      <= mpwm_pkg::PINS_W'(pins);
      ok              <= valid_q;
      pulse_total     <= valid_q ? res_pulse : '0;
      channel_enabled <= valid_q && res_en;
      period_value    <= valid_q ? mpwm_pkg::TICKS_W'(res_period) : '0;
      duty_value      <= valid_q ? mpwm_pkg::TICKS_W'(res_duty) : '0;
    end
  end

endmodule

@@ src/mpwm_mem.sv @@
// Per-channel store of period, duty, phase and pulse count with a registered read port.
module mpwm_mem #(
  parameter int CHANNELS     = 16,
  parameter int COUNTER_BITS = 24,
  parameter int AW           = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [AW-1:0]                   rd_addr,
  input  logic                            wr_en,
  input  logic [AW-1:0]                   wr_addr,
  input  logic [COUNTER_BITS-1:0]         wr_period,
  input  logic [COUNTER_BITS-1:0]         wr_duty,
  input  logic [COUNTER_BITS-1:0]         wr_phase,
  input  logic [mpwm_pkg::PULSE_W-1:0]    wr_pulse,
  output logic [COUNTER_BITS-1:0]         rd_period,
  output logic [COUNTER_BITS-1:0]         rd_duty,
  output logic [COUNTER_BITS-1:0]         rd_phase,
  output logic [mpwm_pkg::PULSE_W-1:0]    rd_pulse
);

  localparam logic [COUNTER_BITS-1:0] RST_PERIOD =
    COUNTER_BITS'(mpwm_pkg::rst_period(COUNTER_BITS));
  localparam logic [COUNTER_BITS-1:0] RST_DUTY =
    COUNTER_BITS'(mpwm_pkg::rst_duty(COUNTER_BITS));

  logic [COUNTER_BITS-1:0]      period_mem [CHANNELS];
  logic [COUNTER_BITS-1:0]      duty_mem   [CHANNELS];
  logic [COUNTER_BITS-1:0]      phase_mem  [CHANNELS];
  logic [mpwm_pkg::PULSE_W-1:0] pulse_mem  [CHANNELS];
  logic [CHANNELS-1:0]          written;

  logic                         rd_hit;
  logic [COUNTER_BITS-1:0]      period_q;
  logic [COUNTER_BITS-1:0]      duty_q;
  logic [COUNTER_BITS-1:0]      phase_q;
  logic [mpwm_pkg::PULSE_W-1:0] pulse_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      period_mem[wr_addr] <= wr_period;
      duty_mem[wr_addr]   <= wr_duty;
      phase_mem[wr_addr]  <= wr_phase;
      pulse_mem[wr_addr]  <= wr_pulse;
    end
    period_q <= period_mem[rd_addr];
    duty_q   <= duty_mem[rd_addr];
    phase_q  <= phase_mem[rd_addr];
    pulse_q  <= pulse_mem[rd_addr];
    rd_hit   <= written[rd_addr];
  end

  // An entry never written since reset reads as the channel defaults.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  assign rd_period = rd_hit ? period_q : RST_PERIOD;
  assign rd_duty   = rd_hit ? duty_q   : RST_DUTY;
  assign rd_phase  = rd_hit ? phase_q  : '0;
  assign rd_pulse  = rd_hit ? pulse_q  : '0;

endmodule

@@ src/mpwm_step.sv @@
// Shared phase-counter unit: advances one channel by one tick.
module mpwm_step #(
  parameter int COUNTER_BITS = 24
) (
  input  logic [COUNTER_BITS-1:0]      period,
  input  logic [COUNTER_BITS-1:0]      duty,
  input  logic [COUNTER_BITS-1:0]      phase,
  input  logic [mpwm_pkg::PULSE_W-1:0] pulse,
  output logic [COUNTER_BITS-1:0]      phase_next,
  output logic [mpwm_pkg::PULSE_W-1:0] pulse_next,
  output logic                         pin_next
);

  logic [COUNTER_BITS:0] incr;
  logic                  wrap;

  always_comb begin
    incr       = {1'b0, phase} + (COUNTER_BITS+1)'(1);
    wrap       = incr >= {1'b0, period};
    phase_next = wrap ? '0 : incr[COUNTER_BITS-1:0];
    pulse_next = wrap ? pulse + mpwm_pkg::PULSE_W'(1) : pulse;
    pin_next   = phase_next < duty;
  end

endmodule

@@ src/mpwm_duty.sv @@
// Duty unit: registered period times Q16 fraction, then round half up and clamp to the period.
module mpwm_duty #(
  parameter int COUNTER_BITS = 24
) (
  input  logic                          clk,
  input  logic [COUNTER_BITS-1:0]       period,
  input  logic [mpwm_pkg::FRAC_W-1:0]   frac,
  output logic [COUNTER_BITS-1:0]       duty
);

  localparam int PW = COUNTER_BITS + mpwm_pkg::FRAC_W;

  logic [mpwm_pkg::FRAC_W-1:0] frac_sat;
  logic [PW-1:0]               prod;
  logic [COUNTER_BITS-1:0]     period_r;
  logic [PW-1:0]               sum;
  logic [COUNTER_BITS:0]       rounded;

  assign frac_sat = (frac > mpwm_pkg::FRAC_ONE) ? mpwm_pkg::FRAC_ONE : frac;

  always_ff @(posedge clk) begin
    prod     <= PW'(period) * PW'(frac_sat);
    period_r <= period;
  end

  // The product stays below 2^(COUNTER_BITS+16), so adding one half cannot overflow.
  always_comb begin
    sum     = prod + PW'(mpwm_pkg::ROUND_HALF);
    rounded = sum[PW-1:mpwm_pkg::FRAC_SHIFT];
    duty    = (rounded > {1'b0, period_r}) ? period_r : rounded[COUNTER_BITS-1:0];
  end

endmodule

@@ test/multichannel_pwm_generator_tb.sv @@
// Self-checking testbench of the multichannel PWM generator with pulse counters.
`timescale 1ns / 1ps

localparam int CHANNEL_COUNT = 16;

// Opcodes that the block does not define; they must answer like a read.
localparam logic [mpwm_pkg::OPCODE_W-1:0] OP_SPARE_A = 3'd6;
localparam logic [mpwm_pkg::OPCODE_W-1:0] OP_SPARE_B = 3'd7;

typedef struct {
  logic [mpwm_pkg::PINS_W-1:0]  pins;
  logic                         ok;
  logic [mpwm_pkg::PULSE_W-1:0] pulses;
  logic                         enabled;
  logic [mpwm_pkg::TICKS_W-1:0] period;
  logic [mpwm_pkg::TICKS_W-1:0] duty;
} pwm_status_t;

class pwm_status_tracker;
  bit [mpwm_pkg::TICKS_W-1:0] period_q [CHANNEL_COUNT];
  bit [mpwm_pkg::TICKS_W-1:0] duty_q   [CHANNEL_COUNT];
  bit [mpwm_pkg::TICKS_W-1:0] phase_q  [CHANNEL_COUNT];
  bit [mpwm_pkg::PULSE_W-1:0] pulses_q [CHANNEL_COUNT];
  bit                         active_q [CHANNEL_COUNT];
  bit                         pin_q    [CHANNEL_COUNT];
  pwm_status_t                expected_status_q [$];
  int                         failures;

  function new();
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      restore_channel(c);
      pulses_q[c] = '0;
    end
    failures = 0;
  endfunction

  function void restore_channel(int c);
    period_q[c] = mpwm_pkg::TICKS_W'(mpwm_pkg::DEF_PERIOD);
    duty_q[c]   = mpwm_pkg::TICKS_W'(mpwm_pkg::DEF_DUTY);
    phase_q[c]  = '0;
    active_q[c] = 1'b0;
    pin_q[c]    = 1'b0;
  endfunction

  // Round half up, then clamp to the period; fractions above one count as one.
  function bit [mpwm_pkg::TICKS_W-1:0] calc_duty(bit [mpwm_pkg::TICKS_W-1:0] per,
                                                 bit [mpwm_pkg::FRAC_W-1:0] frac);
    bit [63:0] f;
    bit [63:0] d;
    f = (frac > mpwm_pkg::FRAC_ONE) ? 64'(mpwm_pkg::FRAC_ONE) : 64'(frac);
    d = (64'(per) * f + 64'(mpwm_pkg::ROUND_HALF)) >> mpwm_pkg::FRAC_SHIFT;
    if (d > 64'(per)) d = 64'(per);
    return d[mpwm_pkg::TICKS_W-1:0];
  endfunction

  function void tick_all_channels();
    bit [mpwm_pkg::TICKS_W:0] n;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      if (active_q[c]) begin
        n = {1'b0, phase_q[c]} + 1'b1;
        if (n >= {1'b0, period_q[c]}) begin
          n = '0;
          pulses_q[c] = pulses_q[c] + 1'b1;
        end
        phase_q[c] = n[mpwm_pkg::TICKS_W-1:0];
        pin_q[c]   = phase_q[c] < duty_q[c];
      end
    end
  endfunction

  function void note_request(logic [mpwm_pkg::OPCODE_W-1:0] op,
                             logic [mpwm_pkg::CHAN_W-1:0] ch,
                             logic [mpwm_pkg::TICKS_W-1:0] per,
                             logic [mpwm_pkg::FRAC_W-1:0] frac,
                             logic en, logic [mpwm_pkg::PULSE_W-1:0] cnt);
    pwm_status_t s;
    bit valid;
    valid = int'(ch) < CHANNEL_COUNT;
    if (op == mpwm_pkg::OP_TICK) begin
      tick_all_channels();
    end else if (valid) begin
      unique case (op)
        mpwm_pkg::OP_SET_PERIOD: begin
          if (per == '0) begin
            restore_channel(ch);
          end else begin
            period_q[ch] = per;
            duty_q[ch]   = calc_duty(per, frac);
            phase_q[ch]  = '0;
            active_q[ch] = 1'b1;
          end
        end
        mpwm_pkg::OP_SET_DUTY: duty_q[ch] = calc_duty(period_q[ch], frac);
        mpwm_pkg::OP_ENABLE: begin
          active_q[ch] = en;
          if (!en) pin_q[ch] = 1'b0;
        end
        mpwm_pkg::OP_SET_PULSES: pulses_q[ch] = cnt;
        default: ;
      endcase
    end
    s.pins = '0;
    for (int c = 0; c < CHANNEL_COUNT; c++) s.pins[c] = pin_q[c];
    s.ok      = valid;
    s.pulses  = valid ? pulses_q[ch] : '0;
    s.enabled = valid && active_q[ch];
    s.period  = valid ? period_q[ch] : '0;
    s.duty    = valid ? duty_q[ch] : '0;
    expected_status_q.push_back(s);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    end
  endfunction

  function void check_status(pwm_status_t got);
    pwm_status_t want;
    if (expected_status_q.size() == 0) begin
      failures++;
      if (failures <= 10) $display("%0t: response with no request outstanding", $realtime);
      return;
    end
    want = expected_status_q.pop_front();
    compare_field("pin_levels", 32'(want.pins), 32'(got.pins));
    compare_field("ok", 32'(want.ok), 32'(got.ok));
    compare_field("pulse_total", want.pulses, got.pulses);
    compare_field("channel_enabled", 32'(want.enabled), 32'(got.enabled));
    compare_field("period_value", 32'(want.period), 32'(got.period));
    compare_field("duty_value", 32'(want.duty), 32'(got.duty));
  endfunction

  function int pending();
    return expected_status_q.size();
  endfunction
endclass

module multichannel_pwm_generator_tb;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_stall;
  logic [mpwm_pkg::OPCODE_W-1:0] opcode = mpwm_pkg::OP_TICK;
  logic [mpwm_pkg::CHAN_W-1:0]   channel = '0;
  logic [mpwm_pkg::TICKS_W-1:0]  period_len = '0;
  logic [mpwm_pkg::FRAC_W-1:0]   duty_fraction = '0;
  logic                          enable_value = 1'b0;
  logic [mpwm_pkg::PULSE_W-1:0]  count_value = '0;
  logic                          rsp_valid;
  logic                          rsp_stall = 1'b0;
  logic [mpwm_pkg::PINS_W-1:0]   pin_levels;
  logic                          ok;
  logic [mpwm_pkg::PULSE_W-1:0]  pulse_total;
  logic                          channel_enabled;
  logic [mpwm_pkg::TICKS_W-1:0]  period_value;
  logic [mpwm_pkg::TICKS_W-1:0]  duty_value;

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;

  pwm_status_tracker bank;

  multichannel_pwm_generator i_dut (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .opcode          (opcode),
    .channel         (channel),
    .period_len      (period_len),
    .duty_fraction   (duty_fraction),
    .enable_value    (enable_value),
    .count_value     (count_value),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .pin_levels      (pin_levels),
    .ok              (ok),
    .pulse_total     (pulse_total),
    .channel_enabled (channel_enabled),
    .period_value    (period_value),
    .duty_value      (duty_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin : rsp_monitor
    pwm_status_t got;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      got.pins    = pin_levels;
      got.ok      = ok;
      got.pulses  = pulse_total;
      got.enabled = channel_enabled;
      got.period  = period_value;
      got.duty    = duty_value;
      bank.check_status(got);
    end
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  // Returns at the edge where the request was taken; the caller's next assignment
  // to req_valid is the only one in that time step.
  task automatic send_request(input logic [mpwm_pkg::OPCODE_W-1:0] op,
                              input logic [mpwm_pkg::CHAN_W-1:0] ch,
                              input logic [mpwm_pkg::TICKS_W-1:0] per,
                              input logic [mpwm_pkg::FRAC_W-1:0] frac,
                              input logic en, input logic [mpwm_pkg::PULSE_W-1:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid     <= 1'b1;
    opcode        <= op;
    channel       <= ch;
    period_len    <= per;
    duty_fraction <= frac;
    enable_value  <= en;
    count_value   <= cnt;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    bank.note_request(op, ch, per, frac, en, cnt);
  endtask

  task automatic send_random_request();
    logic [mpwm_pkg::OPCODE_W-1:0] op;
    logic [mpwm_pkg::TICKS_W-1:0]  per;
    logic [mpwm_pkg::FRAC_W-1:0]   frac;
    logic [mpwm_pkg::PULSE_W-1:0]  cnt;
    int r;
    r = $urandom_range(99);
    if (r < 45)      op = mpwm_pkg::OP_TICK;
    else if (r < 57) op = mpwm_pkg::OP_SET_PERIOD;
    else if (r < 65) op = mpwm_pkg::OP_SET_DUTY;
    else if (r < 75) op = mpwm_pkg::OP_ENABLE;
    else if (r < 82) op = mpwm_pkg::OP_SET_PULSES;
    else if (r < 95) op = mpwm_pkg::OP_READ;
    else if (r < 98) op = OP_SPARE_A;
    else             op = OP_SPARE_B;
    // Short periods keep wraps and pin edges frequent.
    r = $urandom_range(99);
    if (r < 60)      per = mpwm_pkg::TICKS_W'($urandom_range(12, 1));
    else if (r < 72) per = '0;
    else if (r < 87) per = mpwm_pkg::TICKS_W'($urandom_range(2000, 13));
    else if (r < 98) per = mpwm_pkg::TICKS_W'($urandom);
    else             per = '1;
    r = $urandom_range(99);
    if (r < 10)      frac = '0;
    else if (r < 20) frac = mpwm_pkg::FRAC_ONE;
    else if (r < 30) frac = mpwm_pkg::FRAC_W'($urandom_range(131071, 65537));
    else             frac = mpwm_pkg::FRAC_W'($urandom_range(65536));
    cnt = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF - $urandom_range(3) : $urandom;
    send_request(op, mpwm_pkg::CHAN_W'($urandom_range(15)), per, frac,
                 $urandom_range(9) < 7, cnt);
  endtask

  initial begin
    bank = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset values, both unused opcodes.
    send_request(mpwm_pkg::OP_READ, 4'd0, '0, '0, 1'b0, '0);
    send_request(OP_SPARE_A, 4'd15, 24'd77, 17'd100, 1'b1, 32'd5);
    send_request(OP_SPARE_B, 4'd7, '1, '1, 1'b1, '1);
    // Period of one wraps on every tick; fraction above one is clamped.
    send_request(mpwm_pkg::OP_SET_PERIOD, 4'd0, 24'd1, mpwm_pkg::FRAC_ONE, 1'b0, '0);
    send_request(mpwm_pkg::OP_SET_PERIOD, 4'd1, 24'd3, 17'h1FFFF, 1'b0, '0);
    send_request(mpwm_pkg::OP_SET_PERIOD, 4'd2, '1, 17'd1, 1'b0, '0);
    send_request(mpwm_pkg::OP_SET_PERIOD, 4'd3, 24'd4, 17'd32768, 1'b0, '0);
    send_request(mpwm_pkg::OP_TICK, 4'd0, '0, '0, 1'b0, '0);
    send_request(mpwm_pkg::OP_TICK, 4'd9, '0, '0, 1'b0, '0);
    send_request(mpwm_pkg::OP_SET_DUTY, 4'd3, '0, '0, 1'b0, '0);
    send_request(mpwm_pkg::OP_SET_DUTY, 4'd5, '0, 17'd65535, 1'b0, '0);
    // Pulse counter wraps past all ones.
    send_request(mpwm_pkg::OP_SET_PULSES, 4'd0, '0, '0, 1'b0, 32'hFFFF_FFFF);
    send_request(mpwm_pkg::OP_TICK, 4'd0, '0, '0, 1'b0, '0);
    send_request(mpwm_pkg::OP_ENABLE, 4'd1, '0, '0, 1'b0, '0);
    send_request(mpwm_pkg::OP_TICK, 4'd1, '0, '0, 1'b0, '0);
    send_request(mpwm_pkg::OP_ENABLE, 4'd1, '0, '0, 1'b1, '0);
    send_request(mpwm_pkg::OP_ENABLE, 4'd6, '0, '0, 1'b1, '0);
    send_request(mpwm_pkg::OP_TICK, 4'd6, '0, '0, 1'b0, '0);
    // Zero period restores the channel's reset settings but keeps its pulse count.
    send_request(mpwm_pkg::OP_SET_PERIOD, 4'd2, '0, mpwm_pkg::FRAC_ONE, 1'b1, '0);
    send_request(mpwm_pkg::OP_SET_PULSES, 4'd15, '0, '0, 1'b0, 32'hA5A5_5A5A);
    send_request(mpwm_pkg::OP_READ, 4'd15, '0, '0, 1'b0, '0);
    send_request(mpwm_pkg::OP_TICK, 4'd3, '0, '0, 1'b0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 62; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 62; end
        default: begin send_idle_pct = 34; rsp_stall_pct = 34; end
      endcase
      for (int i = 0; i < 457; i++) send_random_request();
    end
    req_valid <= 1'b0;

    while (bank.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (bank.failures == 0 && bank.pending() == 0)
      $display("multichannel_pwm_generator_tb OK");
    else
      $display("multichannel_pwm_generator_tb NOT OK");
    $finish;
  end

  initial begin
    #10ms;
    $display("multichannel_pwm_generator_tb NOT OK");
    $finish;
  end

endmodule
